### rtl/mpt_pkg.sv
// ----------------------------------------------------------------------------
// mpt_pkg
// Shared codes, widths and pattern constants of the memory pattern test engine.
// ----------------------------------------------------------------------------
package mpt_pkg;

   // field widths
   localparam int IdxW   = 22;
   localparam int DataW  = 32;
   localparam int CountW = 23;
   localparam int CsrIdxW = 1;

   // input operation codes
   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // memory command codes
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // pattern codes
   localparam logic [1:0] PAT_ONES  = 2'd0;
   localparam logic [1:0] PAT_ZEROS = 2'd1;
   localparam logic [1:0] PAT_CHK   = 2'd2;
   localparam logic [1:0] PAT_ADDR  = 2'd3;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_BASE_ADDRESS = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_WORD_COUNT   = 1'b1;

   // pattern words
   localparam logic [DataW-1:0] WORD_ONES     = 32'hFFFF_FFFF;
   localparam logic [DataW-1:0] WORD_ZEROS    = 32'h0000_0000;
   localparam logic [DataW-1:0] WORD_CHK_EVEN = 32'hAAAA_AAAA;
   localparam logic [DataW-1:0] WORD_CHK_ODD  = 32'h5555_5555;

   // allowed base address window
   localparam logic [DataW-1:0] WIN_LOW  = 32'hC000_0000;
   localparam logic [DataW-1:0] WIN_SIZE = 32'h0100_0000;
   localparam logic [DataW-1:0] WIN_END  = WIN_LOW + WIN_SIZE;

   // configuration reset values
   localparam logic [DataW-1:0]  BASE_RESET  = 32'hC000_0000;
   localparam logic [CountW-1:0] COUNT_RESET = 23'd2097152;

endpackage

### rtl/memory_pattern_test_engine.sv
// ----------------------------------------------------------------------------
// memory_pattern_test_engine
// Memory self-test sequencer: ones, zeros, checkerboard and address patterns.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per step: op start (check base window and
//   restart) or op advance (carry the word read on the previous step). Each
//   accepted transaction yields exactly one rsp_* transaction holding the
//   memory command to issue (write, read or none) with its word index and
//   write data, and the test status: busy, done, failed, fail index/pattern.
//   csr_* writes base_address (index 0) or word_count (index 1).
// Timing:
//   The response goes valid in the cycle after request acceptance. The next
//   state of the sequencer and the response are formed in one combinational
//   pass over the state registers, so one transaction is taken every cycle
//   unless the response stalls. A stalled response is held in the output
//   register; req_ready drops only while it is full and rsp_ready is low.
// Reset:
//   The sequencer returns to idle with no pending read and a clear fail
//   record; the configuration registers return to their default values.
// ----------------------------------------------------------------------------
module memory_pattern_test_engine #(
   parameter int MAX_WORDS = 4194304
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [mpt_pkg::DataW-1:0]     req_read_data,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_mem_cmd,
   output logic [mpt_pkg::IdxW-1:0]      rsp_word_index,
   output logic [mpt_pkg::DataW-1:0]     rsp_write_data,
   output logic                          rsp_busy_res,
   output logic                          rsp_done_res,
   output logic                          rsp_failed,
   output logic [mpt_pkg::IdxW-1:0]      rsp_fail_index,
   output logic [1:0]                    rsp_fail_pattern,
   // configuration port
   input  logic                          csr_we,
   input  logic [mpt_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [mpt_pkg::DataW-1:0]     csr_wdata
);

   localparam int CntW = (MAX_WORDS > 2) ? $clog2(MAX_WORDS) : 1;
   localparam int EffW = (CntW + 1 > mpt_pkg::CountW) ? CntW + 1 : mpt_pkg::CountW;
   localparam logic [EffW-1:0] MaxEff = EffW'(MAX_WORDS);

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_W_ONES  = 4'd1,
      PH_R_ONES  = 4'd2,
      PH_W_ZEROS = 4'd3,
      PH_R_ZEROS = 4'd4,
      PH_W_CHK   = 4'd5,
      PH_R_CHK   = 4'd6,
      PH_W_ADDR  = 4'd7,
      PH_R_ADDR  = 4'd8,
      PH_DRAIN   = 4'd9,
      PH_DONE    = 4'd10
   } phase_type;

   // configuration
   logic [mpt_pkg::DataW-1:0]  base_address_ff;
   logic [mpt_pkg::CountW-1:0] word_count_ff;

   // sequencer state
   phase_type                  phase_ff, phase_in;
   logic [CntW-1:0]            word_counter_ff, word_counter_in;
   logic                       read_outstanding_ff, read_outstanding_in;
   logic [mpt_pkg::DataW-1:0]  expected_word_ff, expected_word_in;
   logic [CntW-1:0]            check_index_ff, check_index_in;
   logic                       fail_flag_ff, fail_flag_in;
   logic [mpt_pkg::IdxW-1:0]   fail_idx_ff, fail_idx_in;
   logic [1:0]                 fail_pat_ff, fail_pat_in;

   // response register
   logic                       rsp_valid_ff;
   logic [1:0]                 mem_cmd_ff, mem_cmd_in;
   logic [mpt_pkg::IdxW-1:0]   word_index_ff, word_index_in;
   logic [mpt_pkg::DataW-1:0]  write_data_ff, write_data_in;
   logic                       busy_ff, done_ff;
   logic                       failed_ff;
   logic [mpt_pkg::IdxW-1:0]   fail_index_ff;
   logic [1:0]                 fail_pattern_ff;

   // datapath helpers
   logic                       req_accept;
   logic                       running;
   logic                       window_ok;
   logic [EffW-1:0]            counter_ext, check_ext, count_ext, eff_count, counter_inc;
   logic [3:0]                 phase_m1, phase_m2;
   logic [1:0]                 pat_cur, pat_prev;
   logic [mpt_pkg::DataW-1:0]  pattern_w, addr_w;

   assign req_accept = req_valid && req_ready;
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign running    = (phase_ff != PH_IDLE) && (phase_ff != PH_DONE);
   assign window_ok  = (base_address_ff >= mpt_pkg::WIN_LOW) &&
                       (base_address_ff < mpt_pkg::WIN_END);

   assign counter_ext = EffW'(word_counter_ff);
   assign check_ext   = EffW'(check_index_ff);
   assign count_ext   = EffW'(word_count_ff);
   assign eff_count   = (count_ext == '0) ? EffW'(1) :
                        ((count_ext > MaxEff) ? MaxEff : count_ext);
   assign counter_inc = counter_ext + EffW'(1);

   // pattern of the current phase and of the read phase just before it
   assign phase_m1 = phase_ff - 4'd1;
   assign phase_m2 = phase_ff - 4'd2;
   assign pat_cur  = phase_m1[2:1];
   assign pat_prev = (word_counter_ff != '0) ? pat_cur :
                     ((phase_ff == PH_DRAIN) ? mpt_pkg::PAT_ADDR : phase_m2[2:1]);

   assign addr_w = base_address_ff + (32'(counter_ext) << 2);

   always_comb begin
      unique case (pat_cur)
         mpt_pkg::PAT_ONES:  pattern_w = mpt_pkg::WORD_ONES;
         mpt_pkg::PAT_ZEROS: pattern_w = mpt_pkg::WORD_ZEROS;
         mpt_pkg::PAT_CHK:   pattern_w = word_counter_ff[0] ? mpt_pkg::WORD_CHK_ODD
                                                             : mpt_pkg::WORD_CHK_EVEN;
         mpt_pkg::PAT_ADDR:  pattern_w = addr_w;
      endcase
   end

   always_comb begin
      phase_in            = phase_ff;
      word_counter_in     = word_counter_ff;
      read_outstanding_in = read_outstanding_ff;
      expected_word_in    = expected_word_ff;
      check_index_in      = check_index_ff;
      fail_flag_in        = fail_flag_ff;
      fail_idx_in         = fail_idx_ff;
      fail_pat_in         = fail_pat_ff;
      mem_cmd_in          = mpt_pkg::CMD_NONE;
      word_index_in       = '0;
      write_data_in       = '0;

      if (req_op == mpt_pkg::OP_START) begin
         // restart, drop any pending read
         read_outstanding_in = 1'b0;
         word_counter_in     = '0;
         expected_word_in    = '0;
         check_index_in      = '0;
         fail_idx_in         = '0;
         fail_pat_in         = mpt_pkg::PAT_ONES;
         fail_flag_in        = !window_ok;
         phase_in            = window_ok ? PH_W_ONES : PH_DONE;
      end else if (running) begin
         read_outstanding_in = 1'b0;
         if (read_outstanding_ff && (req_read_data != expected_word_ff)) begin
            fail_flag_in = 1'b1;
            fail_idx_in  = check_ext[mpt_pkg::IdxW-1:0];
            fail_pat_in  = pat_prev;
            phase_in     = PH_DONE;
         end else if (phase_ff == PH_DRAIN) begin
            phase_in = PH_DONE;
         end else begin
            word_index_in = counter_ext[mpt_pkg::IdxW-1:0];
            if (phase_ff[0]) begin
               mem_cmd_in    = mpt_pkg::CMD_WRITE;
               write_data_in = pattern_w;
            end else begin
               mem_cmd_in          = mpt_pkg::CMD_READ;
               read_outstanding_in = 1'b1;
               expected_word_in    = pattern_w;
               check_index_in      = word_counter_ff;
            end
            // wrap the counter at the end of the region and advance the phase
            if (counter_inc >= eff_count) begin
               word_counter_in = '0;
               phase_in        = phase_type'(phase_ff + 4'd1);
            end else begin
               word_counter_in = counter_inc[CntW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff     <= mpt_pkg::BASE_RESET;
         word_count_ff       <= mpt_pkg::COUNT_RESET;
         phase_ff            <= PH_IDLE;
         word_counter_ff     <= '0;
         read_outstanding_ff <= 1'b0;
         expected_word_ff    <= '0;
         check_index_ff      <= '0;
         fail_flag_ff        <= 1'b0;
         fail_idx_ff         <= '0;
         fail_pat_ff         <= mpt_pkg::PAT_ONES;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               mpt_pkg::CSR_BASE_ADDRESS: base_address_ff <= csr_wdata;
               mpt_pkg::CSR_WORD_COUNT:   word_count_ff <= csr_wdata[mpt_pkg::CountW-1:0];
            endcase
         end
         if (req_accept) begin
            phase_ff            <= phase_in;
            word_counter_ff     <= word_counter_in;
            read_outstanding_ff <= read_outstanding_in;
            expected_word_ff    <= expected_word_in;
            check_index_ff      <= check_index_in;
            fail_flag_ff        <= fail_flag_in;
            fail_idx_ff         <= fail_idx_in;
            fail_pat_ff         <= fail_pat_in;
            rsp_valid_ff        <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // response payload, no reset needed
      if (req_accept) begin
         mem_cmd_ff      <= mem_cmd_in;
         word_index_ff   <= word_index_in;
         write_data_ff   <= write_data_in;
         busy_ff         <= (phase_in != PH_IDLE) && (phase_in != PH_DONE);
         done_ff         <= (phase_in == PH_DONE);
         failed_ff       <= fail_flag_in;
         fail_index_ff   <= fail_flag_in ? fail_idx_in : '0;
         fail_pattern_ff <= fail_flag_in ? fail_pat_in : mpt_pkg::PAT_ONES;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mem_cmd      = mem_cmd_ff;
   assign rsp_word_index   = word_index_ff;
   assign rsp_write_data   = write_data_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_done_res     = done_ff;
   assign rsp_failed       = failed_ff;
   assign rsp_fail_index   = fail_index_ff;
   assign rsp_fail_pattern = fail_pattern_ff;

`ifndef NO_ASSERTIONS
   // a memory command only goes out while the test is running
   a_cmd_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (mem_cmd_ff != mpt_pkg::CMD_NONE) |-> busy_ff && !done_ff)
      else $error("memory command issued outside a running test");

   // write data is zero unless the command is a write
   a_wdata_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (mem_cmd_ff != mpt_pkg::CMD_WRITE) |-> (write_data_ff == '0))
      else $error("write data set on a non-write command");

   // a pending read exists only inside a running test
   a_read_pending: assert property (@(posedge clock) disable iff (reset)
      read_outstanding_ff |-> running)
      else $error("read pending while idle or done");

   // a recorded failure always ends the test
   a_fail_done: assert property (@(posedge clock) disable iff (reset)
      fail_flag_ff |-> (phase_ff == PH_DONE))
      else $error("failure recorded while test still running");

   // a read response sets up a pending compare for the next step
   a_read_sets_pending: assert property (@(posedge clock) disable iff (reset)
      req_accept && (mem_cmd_in == mpt_pkg::CMD_READ) |=> read_outstanding_ff)
      else $error("read issued without a pending compare");
`endif

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the memory pattern test engine.
// Drives start and advance transactions with random gaps and response stalls,
// predicts every response from an in-bench sequencer copy, and compares each
// response field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_WORDS = 4194304;

   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_FIRST = 4'd1;
   localparam logic [3:0] PH_DRAIN = 4'd9;
   localparam logic [3:0] PH_DONE  = 4'd10;

   typedef struct packed {
      logic [1:0]                mem_cmd;
      logic [mpt_pkg::IdxW-1:0]  word_index;
      logic [mpt_pkg::DataW-1:0] write_data;
      logic                      busy_res;
      logic                      done_res;
      logic                      failed;
      logic [mpt_pkg::IdxW-1:0]  fail_index;
      logic [1:0]                fail_pattern;
   } step_result_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_op;
   logic [mpt_pkg::DataW-1:0]    req_read_data;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [1:0]                   rsp_mem_cmd;
   logic [mpt_pkg::IdxW-1:0]     rsp_word_index;
   logic [mpt_pkg::DataW-1:0]    rsp_write_data;
   logic                         rsp_busy_res;
   logic                         rsp_done_res;
   logic                         rsp_failed;
   logic [mpt_pkg::IdxW-1:0]     rsp_fail_index;
   logic [1:0]                   rsp_fail_pattern;
   logic                         csr_we;
   logic [mpt_pkg::CsrIdxW-1:0]  csr_index;
   logic [mpt_pkg::DataW-1:0]    csr_wdata;

   // predicted engine state and configuration
   logic [mpt_pkg::DataW-1:0]    cfg_base;
   logic [mpt_pkg::CountW-1:0]   cfg_count;
   logic [3:0]                   eng_phase;
   int unsigned                  eng_word;
   logic                         eng_read_pending;
   logic [mpt_pkg::DataW-1:0]    eng_read_word;
   logic [mpt_pkg::IdxW-1:0]     eng_read_index;
   logic                         eng_failed;
   logic [mpt_pkg::IdxW-1:0]     eng_fail_index;
   logic [1:0]                   eng_fail_pattern;

   step_result_type     expected_steps[$];
   int unsigned         mismatch_count;
   int unsigned         items_sent;
   int unsigned         rsp_hold_cycles;
   logic                no_idle;

   memory_pattern_test_engine dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_read_data    (req_read_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mem_cmd      (rsp_mem_cmd),
      .rsp_word_index   (rsp_word_index),
      .rsp_write_data   (rsp_write_data),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_failed       (rsp_failed),
      .rsp_fail_index   (rsp_fail_index),
      .rsp_fail_pattern (rsp_fail_pattern),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic step_result_type next_memory_step(input logic op,
                                                        input logic [mpt_pkg::DataW-1:0] rd);
      step_result_type r;
      logic [mpt_pkg::DataW-1:0] pat_word;
      logic [1:0] pat;
      logic [3:0] rd_phase;
      int unsigned limit;
      logic ok;
      r = '0;
      ok = 1'b1;
      if (op == mpt_pkg::OP_START) begin
         eng_read_pending = 1'b0;
         eng_word = 0;
         eng_read_word = '0;
         eng_read_index = '0;
         eng_fail_index = '0;
         eng_fail_pattern = mpt_pkg::PAT_ONES;
         eng_failed = (cfg_base < mpt_pkg::WIN_LOW) || (cfg_base >= mpt_pkg::WIN_END);
         eng_phase = eng_failed ? PH_DONE : PH_FIRST;
      end else if (eng_phase != PH_IDLE && eng_phase != PH_DONE) begin
         if (eng_read_pending) begin
            eng_read_pending = 1'b0;
            if (rd != eng_read_word) begin
               ok = 1'b0;
               eng_failed = 1'b1;
               eng_fail_index = eng_read_index;
               // the read came from the current phase unless the counter wrapped
               rd_phase = (eng_word != 0) ? eng_phase : eng_phase - 4'd1;
               eng_fail_pattern = 2'((rd_phase - 4'd2) >> 1);
               eng_phase = PH_DONE;
            end
         end
         if (ok) begin
            if (eng_phase == PH_DRAIN) begin
               eng_phase = PH_DONE;
            end else begin
               pat = 2'((eng_phase - 4'd1) >> 1);
               case (pat)
                  mpt_pkg::PAT_ONES:  pat_word = mpt_pkg::WORD_ONES;
                  mpt_pkg::PAT_ZEROS: pat_word = mpt_pkg::WORD_ZEROS;
                  mpt_pkg::PAT_CHK:   pat_word = eng_word[0] ? mpt_pkg::WORD_CHK_ODD
                                                             : mpt_pkg::WORD_CHK_EVEN;
                  default:            pat_word = cfg_base + 32'(eng_word << 2);
               endcase
               r.word_index = eng_word[mpt_pkg::IdxW-1:0];
               if (eng_phase[0]) begin
                  r.mem_cmd = mpt_pkg::CMD_WRITE;
                  r.write_data = pat_word;
               end else begin
                  r.mem_cmd = mpt_pkg::CMD_READ;
                  eng_read_pending = 1'b1;
                  eng_read_word = pat_word;
                  eng_read_index = eng_word[mpt_pkg::IdxW-1:0];
               end
               limit = cfg_count;
               if (limit == 0) limit = 1;
               if (limit > MAX_WORDS) limit = MAX_WORDS;
               eng_word++;
               if (eng_word >= limit) begin
                  eng_word = 0;
                  eng_phase++;
               end
            end
         end
      end
      r.busy_res = (eng_phase != PH_IDLE) && (eng_phase != PH_DONE);
      r.done_res = (eng_phase == PH_DONE);
      r.failed = eng_failed;
      r.fail_index = eng_failed ? eng_fail_index : '0;
      r.fail_pattern = eng_failed ? eng_fail_pattern : mpt_pkg::PAT_ONES;
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      if (mismatch_count < 50) $display("%0t: mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin : check_responses
      step_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_steps.size() == 0) begin
            flag_mismatch("response with no transaction outstanding");
         end else begin
            want = expected_steps.pop_front();
            check_field("mem_cmd", rsp_mem_cmd, want.mem_cmd);
            check_field("word_index", rsp_word_index, want.word_index);
            check_field("write_data", rsp_write_data, want.write_data);
            check_field("busy_res", rsp_busy_res, want.busy_res);
            check_field("done_res", rsp_done_res, want.done_res);
            check_field("failed", rsp_failed, want.failed);
            check_field("fail_index", rsp_fail_index, want.fail_index);
            check_field("fail_pattern", rsp_fail_pattern, want.fail_pattern);
         end
      end
   end

   // response side: random stalls, plus a counted hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(0, 99) >= 34);
         end
      end
   end

   task automatic send_item(input logic op, input logic [mpt_pkg::DataW-1:0] data);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_read_data <= data;
      do @(posedge clock); while (!req_ready);
      expected_steps.push_back(next_memory_step(op, data));
      items_sent++;
   endtask

   task automatic advance_good();
      send_item(mpt_pkg::OP_ADVANCE, eng_read_pending ? eng_read_word : $urandom());
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_steps.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(input logic [mpt_pkg::CsrIdxW-1:0] idx,
                            input logic [mpt_pkg::DataW-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == mpt_pkg::CSR_BASE_ADDRESS) cfg_base = value;
      else cfg_count = value[mpt_pkg::CountW-1:0];
   endtask

   // one start, then advances until the test ends; noisy adds restarts and CSR writes; bad_pct corrupts reads
   task automatic run_pattern_test(input int unsigned bad_pct, input logic noisy);
      logic [mpt_pkg::DataW-1:0] rd;
      int unsigned pick;
      send_item(mpt_pkg::OP_START, $urandom());
      while (eng_phase != PH_DONE) begin
         pick = noisy ? $urandom_range(0, 99) : 99;
         if (pick < 2) begin
            send_item(mpt_pkg::OP_START, $urandom());
         end else if (pick == 2) begin
            write_csr(mpt_pkg::CSR_WORD_COUNT, $urandom_range(1, 6));
         end else if (pick == 3) begin
            write_csr(mpt_pkg::CSR_BASE_ADDRESS, $urandom());
         end else if (pick == 4) begin
            send_item(mpt_pkg::OP_ADVANCE, $urandom());
         end else begin
            rd = eng_read_pending ? eng_read_word : $urandom();
            if (eng_read_pending && $urandom_range(0, 99) < bad_pct)
               rd = rd ^ (32'd1 << $urandom_range(0, 31));
            send_item(mpt_pkg::OP_ADVANCE, rd);
         end
      end
   endtask

   task automatic test_directed();
      // advance before any start
      send_item(mpt_pkg::OP_ADVANCE, mpt_pkg::WORD_ONES);
      // start with the reset configuration, then advance twice
      send_item(mpt_pkg::OP_START, mpt_pkg::WORD_ZEROS);
      advance_good();
      advance_good();
      // window edges and extremes
      write_csr(mpt_pkg::CSR_BASE_ADDRESS, mpt_pkg::WIN_LOW - 32'd1);
      send_item(mpt_pkg::OP_START, mpt_pkg::WORD_ONES);
      send_item(mpt_pkg::OP_ADVANCE, mpt_pkg::WORD_ONES);
      write_csr(mpt_pkg::CSR_BASE_ADDRESS, mpt_pkg::WIN_END);
      send_item(mpt_pkg::OP_START, mpt_pkg::WORD_ZEROS);
      write_csr(mpt_pkg::CSR_BASE_ADDRESS, 32'hFFFF_FFFF);
      send_item(mpt_pkg::OP_START, mpt_pkg::WORD_ZEROS);
      write_csr(mpt_pkg::CSR_BASE_ADDRESS, 32'h0000_0000);
      send_item(mpt_pkg::OP_START, mpt_pkg::WORD_ONES);
      // zero count acts as one word; full clean pass at the top of the window
      write_csr(mpt_pkg::CSR_BASE_ADDRESS, mpt_pkg::WIN_END - 32'd4);
      write_csr(mpt_pkg::CSR_WORD_COUNT, '0);
      run_pattern_test(0, 1'b0);
      // first read comes back wrong
      write_csr(mpt_pkg::CSR_BASE_ADDRESS, mpt_pkg::WIN_LOW);
      write_csr(mpt_pkg::CSR_WORD_COUNT, 32'd1);
      send_item(mpt_pkg::OP_START, mpt_pkg::WORD_ZEROS);
      advance_good();
      advance_good();
      send_item(mpt_pkg::OP_ADVANCE, ~eng_read_word);
   endtask

   task automatic test_large_counts();
      write_csr(mpt_pkg::CSR_WORD_COUNT, 32'h007F_FFFF);
      send_item(mpt_pkg::OP_START, mpt_pkg::WORD_ZEROS);
      repeat (4) advance_good();
      write_csr(mpt_pkg::CSR_WORD_COUNT, MAX_WORDS);
      repeat (3) advance_good();
      write_csr(mpt_pkg::CSR_WORD_COUNT, MAX_WORDS - 1);
      repeat (2) advance_good();
      // shrink below the running counter: phase must wrap at once
      write_csr(mpt_pkg::CSR_WORD_COUNT, 32'd2);
      repeat (3) advance_good();
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (6) begin
         write_csr(mpt_pkg::CSR_WORD_COUNT, $urandom_range(1, 4));
         run_pattern_test(4, 1'b0);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_backpressure();
      write_csr(mpt_pkg::CSR_BASE_ADDRESS, mpt_pkg::WIN_LOW + 32'h100);
      write_csr(mpt_pkg::CSR_WORD_COUNT, 32'd8);
      rsp_hold_cycles = 120;
      run_pattern_test(0, 1'b0);
   endtask

   task automatic test_random_sequences(input int unsigned target);
      int unsigned pick;
      while (items_sent < target) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) write_csr(mpt_pkg::CSR_BASE_ADDRESS, $urandom());
         else if (pick == 1) write_csr(mpt_pkg::CSR_BASE_ADDRESS, mpt_pkg::WIN_LOW);
         else if (pick == 2) write_csr(mpt_pkg::CSR_BASE_ADDRESS, mpt_pkg::WIN_END - 32'd1);
         else write_csr(mpt_pkg::CSR_BASE_ADDRESS,
                        mpt_pkg::WIN_LOW + ($urandom() & 32'h00FF_FFFF));
         pick = $urandom_range(0, 19);
         if (pick == 0) write_csr(mpt_pkg::CSR_WORD_COUNT, 32'd0);
         else if (pick < 16) write_csr(mpt_pkg::CSR_WORD_COUNT, $urandom_range(1, 6));
         else write_csr(mpt_pkg::CSR_WORD_COUNT, $urandom_range(7, 20));
         run_pattern_test(3, $urandom_range(0, 2) == 0);
         // stray advances after the end
         repeat ($urandom_range(0, 2)) send_item(mpt_pkg::OP_ADVANCE, $urandom());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = mpt_pkg::OP_START;
      req_read_data = '0;
      csr_we = 1'b0;
      csr_index = mpt_pkg::CSR_BASE_ADDRESS;
      csr_wdata = '0;
      no_idle = 1'b0;
      rsp_hold_cycles = 0;
      mismatch_count = 0;
      items_sent = 0;
      cfg_base = mpt_pkg::BASE_RESET;
      cfg_count = mpt_pkg::COUNT_RESET;
      eng_phase = PH_IDLE;
      eng_word = 0;
      eng_read_pending = 1'b0;
      eng_read_word = '0;
      eng_read_index = '0;
      eng_failed = 1'b0;
      eng_fail_index = '0;
      eng_fail_pattern = mpt_pkg::PAT_ONES;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_large_counts();
      test_back_to_back();
      test_backpressure();
      test_random_sequences(1150);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_steps.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
